// ===== sv/x87_rsc_pkg.sv =====
// shared types, constants and helpers for the x87 register stack control unit
package x87_rsc_pkg;

  // operation codes
  localparam logic [4:0] K_PUSH_VAL  = 5'd0;
  localparam logic [4:0] K_PUSH_REG  = 5'd1;
  localparam logic [4:0] K_PUSH_CON  = 5'd2;
  localparam logic [4:0] K_READ      = 5'd3;
  localparam logic [4:0] K_READ_POP  = 5'd4;
  localparam logic [4:0] K_COPY      = 5'd5;
  localparam logic [4:0] K_COPY_POP  = 5'd6;
  localparam logic [4:0] K_XCHG      = 5'd7;
  localparam logic [4:0] K_FREE      = 5'd8;
  localparam logic [4:0] K_DEC_TOP   = 5'd9;
  localparam logic [4:0] K_INC_TOP   = 5'd10;
  localparam logic [4:0] K_CMP_REG   = 5'd11;
  localparam logic [4:0] K_CMP_POP   = 5'd12;
  localparam logic [4:0] K_CMP_POP2  = 5'd13;
  localparam logic [4:0] K_CMP_OPND  = 5'd14;
  localparam logic [4:0] K_CMP_OPOP  = 5'd15;
  localparam logic [4:0] K_TEST      = 5'd16;
  localparam logic [4:0] K_EXAMINE   = 5'd17;
  localparam logic [4:0] K_CHS       = 5'd18;
  localparam logic [4:0] K_ABS       = 5'd19;
  localparam logic [4:0] K_CLEX      = 5'd20;
  localparam logic [4:0] K_INIT      = 5'd21;
  localparam logic [4:0] K_LDCW      = 5'd22;
  localparam logic [4:0] K_RDCW      = 5'd23;
  localparam logic [4:0] K_RDSW      = 5'd24;
  localparam logic [4:0] K_POP2      = 5'd25;

  // status word bits
  localparam logic [15:0] SW_IE  = 16'h0001;
  localparam logic [15:0] SW_SF  = 16'h0040;
  localparam logic [15:0] SW_C0  = 16'h0100;
  localparam logic [15:0] SW_C1  = 16'h0200;
  localparam logic [15:0] SW_C2  = 16'h0400;
  localparam logic [15:0] SW_C3  = 16'h4000;
  localparam logic [15:0] SW_CC  = 16'h4700;
  localparam logic [15:0] CW_RESET = 16'h037F;
  localparam logic [15:0] TW_RESET = 16'hFFFF;
  localparam logic [15:0] CLEX_MASK = 16'h7F00;

  localparam logic [1:0] TAG_EMPTY = 2'd3;
  localparam logic [1:0] TAG_VALID = 2'd0;

  localparam logic [63:0] NEG_QNAN  = 64'hFFF8000000000000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000000000000000;
  localparam logic [63:0] MAG_MASK  = 64'h7FFFFFFFFFFFFFFF;

  // constant rom: one, log10(2), log2(e), pi, log2(10), ln(2), +0, +qnan
  localparam logic [63:0] CONST_ROM [8] = '{
    64'h3FF0000000000000, 64'h3FD34413509F79FF, 64'h3FF71547652B82FE,
    64'h400921FB54442D18, 64'h400A934F0979A371, 64'h3FE62E42FEFA39EF,
    64'h0000000000000000, 64'h7FF8000000000000
  };

  // status and tag words moving through one operation
  typedef struct packed {
    logic [15:0] sw;
    logic [15:0] tw;
  } stk_st_t;

  function automatic logic [1:0] tag_of(input logic [15:0] tw, input logic [2:0] p);
    return tw[{p, 1'b0} +: 2];
  endfunction

  function automatic logic [15:0] tag_put(input logic [15:0] tw, input logic [2:0] p,
                                          input logic [1:0] t);
    logic [15:0] r;
    r = tw;
    r[{p, 1'b0} +: 2] = t;
    return r;
  endfunction

  function automatic logic [15:0] empty_sw(input logic [15:0] sw);
    return (sw | SW_IE | SW_SF) & ~SW_C1;
  endfunction

  function automatic logic [15:0] top_step(input logic [15:0] sw, input logic up);
    logic [15:0] r;
    r = sw;
    r[13:11] = up ? sw[13:11] + 3'd1 : sw[13:11] - 3'd1;
    return r;
  endfunction

  // push bookkeeping; the new value lands at the new top
  function automatic stk_st_t push_st(input stk_st_t s);
    stk_st_t r;
    r = s;
    if (tag_of(s.tw, s.sw[13:11] + 3'd7) != TAG_EMPTY) r.sw = r.sw | SW_IE | SW_C1 | SW_SF;
    r.sw = top_step(r.sw, 1'b0);
    r.tw = tag_put(r.tw, r.sw[13:11], TAG_VALID);
    return r;
  endfunction

  // pop bookkeeping
  function automatic stk_st_t pop_st(input stk_st_t s);
    stk_st_t r;
    r = s;
    if (tag_of(s.tw, s.sw[13:11]) != TAG_EMPTY) r.tw = tag_put(r.tw, s.sw[13:11], TAG_EMPTY);
    else r.sw = empty_sw(r.sw);
    r.sw = top_step(r.sw, 1'b1);
    return r;
  endfunction

  function automatic logic is_nan(input logic [63:0] a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != '0);
  endfunction

  // compare st0 against y, updating condition codes
  function automatic logic [15:0] cmp_sw(input logic [15:0] sw, input logic [63:0] x,
                                         input logic [63:0] y);
    logic [15:0] r;
    logic eq, lt;
    r = sw & ~SW_CC;
    eq = (x == y) || ((x[62:0] == '0) && (y[62:0] == '0));
    if (eq) lt = 1'b0;
    else if (x[63] != y[63]) lt = x[63];
    else if (!x[63]) lt = x[62:0] < y[62:0];
    else lt = x[62:0] > y[62:0];
    if (is_nan(x) || is_nan(y)) begin
      r = r | SW_C0 | SW_C2 | SW_C3 | SW_IE;
    end else begin
      if (lt) r = r | SW_C0;
      if (eq) r = r | SW_C3;
    end
    return r;
  endfunction

endpackage

// ===== sv/x87_register_stack_control_unit.sv =====
// x87 register stack control unit: input register, one operation pass, result register
// order: a beat accepted into the input register passes the operation logic, loads the result register,
// and is shown with valid_o once the result register holds it
// throughput: one operation per cycle; busy is never raised, the receiver cannot stall
// each operation is one pass of flat logic between the input and result registers
// reset: tags empty, status zero, control word 037f; stack values undefined until written
module x87_register_stack_control_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  kind_i,
  input  logic [2:0]  reg_index_i,
  input  logic [63:0] operand_bits_i,
  input  logic [15:0] word_in_i,
  output logic        valid_o,
  output logic [63:0] value_bits_o,
  output logic [15:0] word_out_o,
  output logic [15:0] status_now_o
);
  import x87_rsc_pkg::*;

  logic        in_vld_q;
  logic [4:0]  kind_q;
  logic [2:0]  ri_q;
  logic [63:0] opnd_q;
  logic [15:0] win_q;

  logic [63:0] stack_q [8];
  logic [15:0] tag_q, status_q, ctrl_q;
  logic [15:0] tag_d, status_d, ctrl_d;
  logic        out_vld_q;
  logic [63:0] value_q, value_d;
  logic [15:0] word_q, word_d;

  logic        we0, we1;
  logic [2:0]  wa0, wa1;
  logic [63:0] wd0, wd1;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      kind_q <= kind_i;
      ri_q   <= reg_index_i;
      opnd_q <= operand_bits_i;
      win_q  <= word_in_i;
    end
  end

  // operation pass
  always_comb begin
    stk_st_t     s;
    logic [2:0]  top, p0, pr;
    logic        e0, er;
    logic [63:0] x0, xr;
    logic [15:0] cc;
    top = status_q[13:11];
    p0  = top;
    pr  = top + ((kind_q == K_CMP_POP2) ? 3'd1 : ri_q);
    e0  = tag_of(tag_q, p0) == TAG_EMPTY;
    er  = tag_of(tag_q, pr) == TAG_EMPTY;
    x0  = e0 ? NEG_QNAN : stack_q[p0];
    xr  = er ? NEG_QNAN : stack_q[pr];
    s.sw = status_q;
    s.tw = tag_q;
    ctrl_d  = ctrl_q;
    value_d = '0;
    word_d  = '0;
    we0 = 1'b0; wa0 = p0; wd0 = x0;
    we1 = 1'b0; wa1 = pr; wd1 = x0;
    cc = '0;
    if (in_vld_q) begin
      unique case (kind_q)
        K_PUSH_VAL: begin
          s = push_st(s);
          we0 = 1'b1; wa0 = top - 3'd1; wd0 = opnd_q;
        end
        K_PUSH_REG: begin
          if (er) s.sw = empty_sw(s.sw);
          s = push_st(s);
          we0 = 1'b1; wa0 = top - 3'd1; wd0 = xr;
        end
        K_PUSH_CON: begin
          s = push_st(s);
          we0 = 1'b1; wa0 = top - 3'd1; wd0 = CONST_ROM[ri_q];
        end
        K_READ: begin
          if (e0) s.sw = empty_sw(s.sw);
          value_d = x0;
        end
        K_READ_POP: begin
          if (e0) s.sw = empty_sw(s.sw);
          value_d = x0;
          s = pop_st(s);
        end
        K_COPY, K_COPY_POP: begin
          if (e0) s.sw = empty_sw(s.sw);
          we1 = 1'b1;
          s.tw = tag_put(s.tw, pr, TAG_VALID);
          if (kind_q == K_COPY_POP) s = pop_st(s);
        end
        K_XCHG: begin
          if (e0 || er) s.sw = empty_sw(s.sw);
          we1 = 1'b1;
          we0 = 1'b1; wd0 = xr;
          s.tw = tag_put(s.tw, pr, TAG_VALID);
          s.tw = tag_put(s.tw, p0, TAG_VALID);
        end
        K_FREE:    s.tw = tag_put(s.tw, pr, TAG_EMPTY);
        K_DEC_TOP: s.sw = top_step(s.sw, 1'b0);
        K_INC_TOP: s.sw = top_step(s.sw, 1'b1);
        K_CMP_REG, K_CMP_POP, K_CMP_POP2: begin
          if (e0 || er) s.sw = empty_sw(s.sw);
          s.sw = cmp_sw(s.sw, x0, xr);
          if (kind_q != K_CMP_REG) s = pop_st(s);
          if (kind_q == K_CMP_POP2) s = pop_st(s);
        end
        K_CMP_OPND, K_CMP_OPOP, K_TEST: begin
          if (e0) s.sw = empty_sw(s.sw);
          s.sw = cmp_sw(s.sw, x0, (kind_q == K_TEST) ? 64'd0 : opnd_q);
          if (kind_q == K_CMP_OPOP) s = pop_st(s);
        end
        K_EXAMINE: begin
          if (e0) s.sw = empty_sw(s.sw);
          if (x0[63]) cc = cc | SW_C1;
          if (e0) cc = cc | SW_C0 | SW_C3;
          else if (x0[62:52] == 11'h7FF)
            cc = cc | ((x0[51:0] != '0) ? SW_C0 : (SW_C0 | SW_C2));
          else if (x0[62:52] == '0)
            cc = cc | ((x0[51:0] == '0) ? SW_C3 : (SW_C3 | SW_C2));
          else cc = cc | SW_C2;
          s.sw = (s.sw & ~SW_CC) | cc;
        end
        K_CHS, K_ABS: begin
          if (e0) s.sw = empty_sw(s.sw);
          we0 = 1'b1;
          wd0 = (kind_q == K_CHS) ? (x0 ^ SIGN_BIT) : (x0 & MAG_MASK);
        end
        K_CLEX: s.sw = s.sw & CLEX_MASK;
        K_INIT: begin
          ctrl_d = CW_RESET;
          s.sw = '0;
          s.tw = TW_RESET;
        end
        K_LDCW: ctrl_d = win_q;
        K_RDCW: word_d = ctrl_q;
        K_RDSW: word_d = status_q;
        K_POP2: begin
          s = pop_st(s);
          s = pop_st(s);
        end
        default: ;
      endcase
    end
    status_d = s.sw;
    tag_d    = s.tw;
  end

  // architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= TW_RESET;
      status_q  <= '0;
      ctrl_q    <= CW_RESET;
      out_vld_q <= 1'b0;
    end else begin
      tag_q     <= tag_d;
      status_q  <= status_d;
      ctrl_q    <= ctrl_d;
      out_vld_q <= in_vld_q;
    end
  end

  // stack storage; the second port wins on a shared address (same data there)
  always_ff @(posedge clk_i) begin
    if (we0) stack_q[wa0] <= wd0;
    if (we1) stack_q[wa1] <= wd1;
    if (in_vld_q) begin
      value_q <= value_d;
      word_q  <= word_d;
    end
  end

  assign valid_o      = out_vld_q;
  assign value_bits_o = value_q;
  assign word_out_o   = word_q;
  assign status_now_o = status_q;

endmodule

// ===== sv/x87_rsc_checker.sv =====
// port-level checker for the x87 register stack control unit, bound to the top level
module x87_rsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [4:0]  kind_i,
  input logic        valid_o,
  input logic [15:0] word_out_o,
  input logic [15:0] status_now_o
);
  import x87_rsc_pkg::*;

  // every accepted beat yields one result, through the input and result registers
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 valid_o) else $error("missing result");

  // no result without an accepted beat
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> ##1 !valid_o) else $error("spurious result");

  // status read returns the status word shown with it
  a_rdsw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == K_RDSW) |=> ##1 (word_out_o == status_now_o))
    else $error("status read mismatch");

  // init leaves an all-zero status word
  a_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == K_INIT) |=> ##1 (status_now_o == 16'h0000))
    else $error("init status not clear");

endmodule

bind x87_register_stack_control_unit x87_rsc_checker u_x87_rsc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .kind_i(kind_i),
  .valid_o(valid_o), .word_out_o(word_out_o), .status_now_o(status_now_o)
);
